>>> src/ccee_pkg.sv
// ----------------------------------------------------------------------------
// ccee_pkg: shared types and constants of the escape encoder
// Character codes, keep-mask bit positions and the escape descriptor that
// travels from the classifier to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccee_pkg;

   // keep mask bit positions
   localparam int unsigned CLS_UPPER   = 0;
   localparam int unsigned CLS_LOWER   = 1;
   localparam int unsigned CLS_DIGIT   = 2;
   localparam int unsigned CLS_DASH    = 3;
   localparam int unsigned CLS_UNDER   = 4;
   localparam int unsigned CLS_DOT     = 5;
   localparam int unsigned CLS_SPACE   = 6;
   localparam int unsigned CLS_TAB     = 7;
   localparam int unsigned CLS_NEWLINE = 8;
   localparam int unsigned KEEP_W      = 9;

   // character codes
   localparam logic [7:0] CHR_BS     = 8'h5C;
   localparam logic [7:0] CHR_T      = 8'h74;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_UP_A   = 8'h41;
   localparam logic [7:0] CHR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHR_LO_A   = 8'h61;
   localparam logic [7:0] CHR_LO_Z   = 8'h7A;
   localparam logic [7:0] CHR_DASH   = 8'h2D;
   localparam logic [7:0] CHR_UNDER  = 8'h5F;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_BSPACE = 8'h08;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   // descriptor queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // up to four output characters for one input byte
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
   } esc_desc_type;

endpackage

`default_nettype wire

>>> src/ccee_front.sv
// ----------------------------------------------------------------------------
// ccee_front: keep-mask register and byte classifier
// Decides per input byte whether it passes or is escaped and builds the
// full character sequence for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ccee_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire  [ccee_pkg::KEEP_W-1:0] csr_wdata,
   input  wire  [7:0]                  byte_in,
   output ccee_pkg::esc_desc_type      desc
);
   import ccee_pkg::*;

   logic [KEEP_W-1:0] keep_ff;
   logic [KEEP_W-1:0] keep_in;
   logic              kept;
   logic [2:0]        dig2;
   logic [2:0]        dig1;
   logic [2:0]        dig0;

   // keep mask register
   always_comb begin
      keep_in = csr_we ? csr_wdata : keep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= '0;
      end else begin
         keep_ff <= keep_in;
      end
   end

   // class membership
   always_comb begin
      kept = (keep_ff[CLS_UPPER] && byte_in >= CHR_UP_A && byte_in <= CHR_UP_Z)
          || (keep_ff[CLS_LOWER] && byte_in >= CHR_LO_A && byte_in <= CHR_LO_Z)
          || (keep_ff[CLS_DIGIT] && byte_in >= CHR_ZERO && byte_in <= CHR_NINE)
          || (keep_ff[CLS_DASH] && byte_in == CHR_DASH)
          || (keep_ff[CLS_UNDER] && byte_in == CHR_UNDER)
          || (keep_ff[CLS_DOT] && byte_in == CHR_DOT)
          || (keep_ff[CLS_SPACE] && byte_in == CHR_SPACE)
          || (keep_ff[CLS_TAB] && byte_in == CHR_TAB)
          || (keep_ff[CLS_NEWLINE] && (byte_in == CHR_LF || byte_in == CHR_CR));
   end

   // octal digits, most significant first
   assign dig2 = {1'b0, byte_in[7:6]};
   assign dig1 = byte_in[5:3];
   assign dig0 = byte_in[2:0];

   // character sequence; line feed and carriage return letters are intentionally swapped, backspace gives t
   always_comb begin
      desc.chars    = '0;
      desc.last_idx = 2'd1;
      if (kept) begin
         desc.chars[0] = byte_in;
         desc.last_idx = 2'd0;
      end else begin
         desc.chars[0] = CHR_BS;
         priority if (byte_in == CHR_BSPACE) begin
            desc.chars[1] = CHR_T;
         end else if (byte_in == CHR_LF) begin
            desc.chars[1] = CHR_R;
         end else if (byte_in == CHR_CR) begin
            desc.chars[1] = CHR_N;
         end else if (byte_in == CHR_BS) begin
            desc.chars[1] = CHR_BS;
         end else if (dig2 != 3'd0) begin
            desc.chars[1] = CHR_ZERO | {5'd0, dig2};
            desc.chars[2] = CHR_ZERO | {5'd0, dig1};
            desc.chars[3] = CHR_ZERO | {5'd0, dig0};
            desc.last_idx = 2'd3;
         end else if (dig1 != 3'd0) begin
            desc.chars[1] = CHR_ZERO | {5'd0, dig1};
            desc.chars[2] = CHR_ZERO | {5'd0, dig0};
            desc.last_idx = 2'd2;
         end else begin
            desc.chars[1] = CHR_ZERO | {5'd0, dig0};
         end
      end
   end

endmodule

`default_nettype wire

>>> src/ccee_fifo.sv
// ----------------------------------------------------------------------------
// ccee_fifo: descriptor queue
// Short first-in first-out queue that decouples the classifier from the
// serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ccee_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  ccee_pkg::esc_desc_type  push_desc,
   input  wire                     pop,
   output ccee_pkg::esc_desc_type  head_desc,
   output logic                    full,
   output logic                    empty
);
   import ccee_pkg::*;

   esc_desc_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

>>> src/ccee_back.sv
// ----------------------------------------------------------------------------
// ccee_back: character serializer
// Walks the head descriptor into a registered output stage one character per
// cycle unless stalled, and releases the descriptor with its last character.
// ----------------------------------------------------------------------------
`default_nettype none

module ccee_back (
   input  wire                     clock,
   input  wire                     reset,
   input  ccee_pkg::esc_desc_type  head_desc,
   input  wire                     empty,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import ccee_pkg::*;

   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       last_ff;
   logic       last_in;
   logic       advance;
   logic       at_last;

   assign advance = !valid_ff || rsp_tready;
   assign at_last = (idx_ff == head_desc.last_idx);
   assign pop     = advance && !empty && at_last;

   // next character selection
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = !empty;
         if (!empty) begin
            data_in = head_desc.chars[idx_ff];
            last_in = at_last;
            idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

>>> src/char_class_escape_encoder.sv
// ----------------------------------------------------------------------------
// char_class_escape_encoder: byte string escape encoder
// Passes bytes of enabled character classes and escapes all others with
// backslash letter, doubled backslash or backslash octal sequences.
// ----------------------------------------------------------------------------
// One input byte per transaction yields one to four output characters; the
// last one is marked with rsp_tlast. The output port moves one character
// per cycle while rsp_tready is high; a kept byte gives one character, a
// letter, backslash or one-digit octal escape two, a two-digit octal escape
// three and a three-digit octal escape four. Input bytes are classified on
// arrival and queued in a four-entry descriptor queue, so a new byte is
// taken every cycle while the queue has room, even when the output is stalled.
// Each byte passes through its queue slot and then the registered output
// stage. The keep mask (csr_wdata) is written with csr_we and must only
// change while no byte is in flight; bits from low to high enable
// capitals, lowercase, digits, dash, underscore, dot, space, tab and
// newlines (10 and 13). Note that an escaped byte 10 gives backslash r
// and byte 13 gives backslash n.
`default_nettype none

module char_class_escape_encoder (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire  [ccee_pkg::KEEP_W-1:0] csr_wdata,  // keep_classes
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [7:0]                  req_tdata,  // [7:0] byte_in
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [7:0]                  rsp_tdata,  // [7:0] byte_out
   output logic                        rsp_tlast   // run_end
);
   import ccee_pkg::*;

   esc_desc_type new_desc;
   esc_desc_type head_desc;
   logic         fifo_full;
   logic         fifo_empty;
   logic         fifo_pop;

   assign req_tready = !fifo_full;

   // classifier
   ccee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .byte_in   (req_tdata),
      .desc      (new_desc)
   );

   // descriptor queue
   ccee_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_desc (new_desc),
      .pop       (fifo_pop),
      .head_desc (head_desc),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // serializer
   ccee_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .empty      (fifo_empty),
      .pop        (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> src/ccee_checker.sv
// ----------------------------------------------------------------------------
// ccee_checker: port-level checks of the escape encoder
// Tracks bytes in flight and checks output ordering against the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ccee_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast
);
   import ccee_pkg::*;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       prev_last_ff;
   logic       prev_last_in;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       run_done;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign run_done = rsp_xfer && rsp_tlast;

   // bytes accepted whose run is not yet complete
   always_comb begin
      pending_in   = pending_ff + {3'd0, req_xfer} - {3'd0, run_done};
      prev_last_in = rsp_xfer ? rsp_tlast : prev_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         prev_last_ff <= 1'b1;
      end else begin
         pending_ff   <= pending_in;
         prev_last_ff <= prev_last_in;
      end
   end

   // output is quiet right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // no output without an accepted byte behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("output transaction without pending input byte");

   // in-flight bytes bounded by queue plus output stage
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(FIFO_DEPTH + 1))
      else $error("too many bytes in flight");

   // a multi-character run always opens with a backslash
   a_escape_start: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tlast && prev_last_ff |-> rsp_tdata == CHR_BS)
      else $error("escape run does not start with backslash");

   // stalled output transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tlast))
      else $error("stalled output transaction changed");

endmodule

bind char_class_escape_encoder ccee_checker u_ccee_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
